### rtl/core/conv2d_valid_stride_mac_core_defines.svh
// Assertion macros for the convolution core checker.
`ifndef CONV2D_VALID_STRIDE_MAC_CORE_DEFINES_SVH
`define CONV2D_VALID_STRIDE_MAC_CORE_DEFINES_SVH
// Assert an implication, clocked and disabled by reset.
`define CVS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Assert an implication in the next cycle.
`define CVS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

### rtl/core/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// Types, constants and helpers shared by the convolution core.
// ----------------------------------------------------------------------------
`default_nettype none
package cvs_pkg;
    localparam int MAX_ROWS_D     = 64;
    localparam int MAX_COLS_D     = 64;
    localparam int MAX_CHANNELS_D = 16;
    localparam int MAX_FILTERS_D  = 16;
    localparam int MAX_KERNEL_D   = 5;

    localparam logic [1:0] OP_LOAD_IN   = 2'd0;
    localparam logic [1:0] OP_LOAD_W    = 2'd1;
    localparam logic [1:0] OP_LOAD_BIAS = 2'd2;
    localparam logic [1:0] OP_COMPUTE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_KROWS    = 3'd1;
    localparam logic [2:0] REG_KCOLS    = 3'd2;
    localparam logic [2:0] REG_RSTEP    = 3'd3;
    localparam logic [2:0] REG_CSTEP    = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [3:0]  chan;
        logic [3:0]  filt;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [4:0] channels_in_use;
        logic [2:0] kernel_rows;
        logic [2:0] kernel_cols;
        logic [2:0] row_step;
        logic [2:0] col_step;
    } cfg_t;
endpackage
`default_nettype wire

### rtl/core/cvs_if.sv
// ----------------------------------------------------------------------------
// cvs_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface cvs_item_if;
    logic           valid;
    logic           ready;
    cvs_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cvs_result_if;
    logic             valid;
    logic             ready;
    cvs_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cvs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### rtl/core/cvs_front.sv
// ----------------------------------------------------------------------------
// cvs_front
// Accepts items into a two-entry queue and hands them to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module cvs_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    cvs_item_if.sink            in_ch,
    output cvs_pkg::item_t      q_item,
    output logic                q_valid,
    input  wire logic           q_pop,
    output logic                busy
);
    cvs_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_item      = mem_reg[rp_reg];
    assign busy        = q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

### rtl/core/cvs_back.sv
// ----------------------------------------------------------------------------
// cvs_back
// Executes loads and runs the multiply-accumulate sequencer for computes.
// ----------------------------------------------------------------------------
`default_nettype none
module cvs_back #(
    parameter int MAX_ROWS     = cvs_pkg::MAX_ROWS_D,
    parameter int MAX_COLS     = cvs_pkg::MAX_COLS_D,
    parameter int MAX_CHANNELS = cvs_pkg::MAX_CHANNELS_D,
    parameter int MAX_FILTERS  = cvs_pkg::MAX_FILTERS_D,
    parameter int MAX_KERNEL   = cvs_pkg::MAX_KERNEL_D
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  cvs_pkg::cfg_t       cfg,
    input  cvs_pkg::item_t      q_item,
    input  wire logic           q_valid,
    output logic                q_pop,
    cvs_result_if.source        out_ch,
    output logic                busy
);
    localparam int IN_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
    localparam int W_DEPTH  = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
    localparam int IAW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int FW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int CW  = $clog2(MAX_CHANNELS + 1);
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int PW  = 20;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_DRAIN, S_SAT, S_OUT} state_t;

    logic signed [15:0] in_mem [IN_DEPTH];
    logic signed [15:0] w_mem  [W_DEPTH];
    logic signed [15:0] bias_reg [MAX_FILTERS];
    logic [MAX_FILTERS-1:0] bias_vld_reg;

    state_t state_reg;
    cvs_pkg::item_t it_reg;
    logic [CW-1:0] nc_reg, c_reg;
    logic [KW-1:0] kr_reg, kc_reg, ky_reg, kx_reg;
    logic [PW-1:0] y0_reg, x0_reg;
    logic signed [40:0] acc_reg;
    logic signed [15:0] ird_reg, wrd_reg;
    logic rdv_reg, rdv2_reg;
    logic signed [31:0] prod_reg;
    logic [IAW-1:0] ia;
    logic [WAW-1:0] wa;
    logic last_tap;
    logic out_valid_reg;
    cvs_pkg::result_t out_reg;
    logic range_bad;
    logic [PW-1:0] ylast, xlast;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
    assign busy = (state_reg != S_IDLE) || out_valid_reg;

    always_comb
    begin
        ia = IAW'(((32'(y0_reg) + 32'(ky_reg)) * MAX_COLS + 32'(x0_reg) + 32'(kx_reg))
                  * MAX_CHANNELS + 32'(c_reg));
        wa = WAW'(((32'(it_reg.filt) * MAX_KERNEL + 32'(ky_reg)) * MAX_KERNEL
                   + 32'(kx_reg)) * MAX_CHANNELS + 32'(c_reg));
        last_tap = (c_reg == nc_reg - CW'(1)) && (kx_reg == kc_reg - KW'(1))
                   && (ky_reg == kr_reg - KW'(1));
        ylast = y0_reg + PW'(kr_reg) - PW'(1);
        xlast = x0_reg + PW'(kc_reg) - PW'(1);
        range_bad = (32'(it_reg.filt) >= MAX_FILTERS)
                    || (kr_reg != '0 && 32'(ylast) >= MAX_ROWS)
                    || (kc_reg != '0 && 32'(xlast) >= MAX_COLS);
    end

    assign q_pop = q_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.op == cvs_pkg::OP_LOAD_IN && 32'(q_item.row) < MAX_ROWS
            && 32'(q_item.col) < MAX_COLS && 32'(q_item.chan) < MAX_CHANNELS)
        begin
            in_mem[IAW'((32'(q_item.row) * MAX_COLS + 32'(q_item.col)) * MAX_CHANNELS
                        + 32'(q_item.chan))] <= q_item.value;
        end
        if (q_pop && q_item.op == cvs_pkg::OP_LOAD_W && 32'(q_item.filt) < MAX_FILTERS
            && 32'(q_item.row) < MAX_KERNEL && 32'(q_item.col) < MAX_KERNEL
            && 32'(q_item.chan) < MAX_CHANNELS)
        begin
            w_mem[WAW'(((32'(q_item.filt) * MAX_KERNEL + 32'(q_item.row)) * MAX_KERNEL
                        + 32'(q_item.col)) * MAX_CHANNELS + 32'(q_item.chan))] <= q_item.value;
        end
        if (q_pop && q_item.op == cvs_pkg::OP_LOAD_BIAS && 32'(q_item.filt) < MAX_FILTERS)
        begin
            bias_reg[FW'(q_item.filt)] <= q_item.value;
        end
        ird_reg  <= in_mem[ia];
        wrd_reg  <= w_mem[wa];
        prod_reg <= ird_reg * wrd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            bias_vld_reg  <= '0;
            acc_reg       <= '0;
            rdv_reg       <= 1'b0;
            rdv2_reg      <= 1'b0;
            it_reg        <= '0;
            nc_reg <= '0; kr_reg <= '0; kc_reg <= '0;
            c_reg  <= '0; ky_reg <= '0; kx_reg <= '0;
            y0_reg <= '0; x0_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rdv_reg  <= 1'b0;
            rdv2_reg <= rdv_reg;
            if (rdv2_reg)
            begin
                acc_reg <= acc_reg + 41'(prod_reg);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_item.op == cvs_pkg::OP_LOAD_BIAS
                        && 32'(q_item.filt) < MAX_FILTERS)
                    begin
                        bias_vld_reg[FW'(q_item.filt)] <= 1'b1;
                    end
                    if (q_pop && q_item.op == cvs_pkg::OP_COMPUTE)
                    begin
                        it_reg <= q_item;
                        nc_reg <= (32'(cfg.channels_in_use) > MAX_CHANNELS)
                                  ? CW'(MAX_CHANNELS) : CW'(cfg.channels_in_use);
                        kr_reg <= (32'(cfg.kernel_rows) > MAX_KERNEL)
                                  ? KW'(MAX_KERNEL) : KW'(cfg.kernel_rows);
                        kc_reg <= (32'(cfg.kernel_cols) > MAX_KERNEL)
                                  ? KW'(MAX_KERNEL) : KW'(cfg.kernel_cols);
                        y0_reg <= PW'(q_item.row) * PW'(cfg.row_step);
                        x0_reg <= PW'(q_item.col) * PW'(cfg.col_step);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    c_reg <= '0; ky_reg <= '0; kx_reg <= '0;
                    if (range_bad)
                    begin
                        if (!out_valid_reg)
                        begin
                            out_reg <= '{result_value: 32'd0, status: cvs_pkg::ST_RANGE};
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        acc_reg <= bias_vld_reg[FW'(it_reg.filt)]
                                   ? 41'(bias_reg[FW'(it_reg.filt)]) <<< 8 : '0;
                        state_reg <= (nc_reg == '0 || kr_reg == '0 || kc_reg == '0)
                                     ? S_SAT : S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    rdv_reg <= 1'b1;
                    if (last_tap)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else if (c_reg != nc_reg - CW'(1))
                    begin
                        c_reg <= c_reg + CW'(1);
                    end
                    else
                    begin
                        c_reg <= '0;
                        if (kx_reg != kc_reg - KW'(1))
                        begin
                            kx_reg <= kx_reg + KW'(1);
                        end
                        else
                        begin
                            kx_reg <= '0;
                            ky_reg <= ky_reg + KW'(1);
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!rdv_reg && !rdv2_reg)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        if (acc_reg > 41'sh0_7FFF_FFFF)
                        begin
                            out_reg <= '{result_value: 32'h7FFF_FFFF,
                                         status: cvs_pkg::ST_SAT};
                        end
                        else if (acc_reg < -41'sh0_8000_0000)
                        begin
                            out_reg <= '{result_value: 32'h8000_0000,
                                         status: cvs_pkg::ST_SAT};
                        end
                        else
                        begin
                            out_reg <= '{result_value: acc_reg[31:0],
                                         status: cvs_pkg::ST_OK};
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/conv2d_valid_stride_mac_core.sv
// ----------------------------------------------------------------------------
// conv2d_valid_stride_mac_core
// Strided valid-padding 2D convolution with Q8.8 stores and a Q16.16 result.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     in    op, row, col, chan, filt, value
//  out_ch    out   result_value, status
//  cfg_ch    in    index, wdata
// A load is written to its store when the back end takes it from the queue. A
// compute runs check, issue, drain, sat and out, one multiply-accumulate per
// cycle in issue; an out-of-range window returns from check, and an empty
// kernel skips issue and drain. Reset returns the configuration to its defaults and
// clears the bias store. A stalled result holds only the next result; loads
// keep draining and the two-entry queue fills only behind a running compute.
`default_nettype none
module conv2d_valid_stride_mac_core #(
    parameter int MAX_ROWS     = cvs_pkg::MAX_ROWS_D,
    parameter int MAX_COLS     = cvs_pkg::MAX_COLS_D,
    parameter int MAX_CHANNELS = cvs_pkg::MAX_CHANNELS_D,
    parameter int MAX_FILTERS  = cvs_pkg::MAX_FILTERS_D,
    parameter int MAX_KERNEL   = cvs_pkg::MAX_KERNEL_D
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cvs_item_if.sink      in_ch,
    cvs_result_if.source  out_ch,
    cvs_cfg_if.sink       cfg_ch
);
    cvs_pkg::cfg_t  cfg_reg;
    cvs_pkg::item_t q_item;
    logic q_valid, q_pop, fbusy, bbusy;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{channels_in_use: 5'd1, kernel_rows: 3'd3, kernel_cols: 3'd3,
                         row_step: 3'd1, col_step: 3'd1};
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                cvs_pkg::REG_CHANNELS: cfg_reg.channels_in_use <= cfg_ch.wdata[4:0];
                cvs_pkg::REG_KROWS:    cfg_reg.kernel_rows     <= cfg_ch.wdata[2:0];
                cvs_pkg::REG_KCOLS:    cfg_reg.kernel_cols     <= cfg_ch.wdata[2:0];
                cvs_pkg::REG_RSTEP:    cfg_reg.row_step        <= cfg_ch.wdata[2:0];
                cvs_pkg::REG_CSTEP:    cfg_reg.col_step        <= cfg_ch.wdata[2:0];
                default: ;
            endcase
        end
    end

    cvs_front u_front (
        .clk, .rst_n, .in_ch, .q_item, .q_valid, .q_pop, .busy(fbusy)
    );

    cvs_back #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_CHANNELS(MAX_CHANNELS),
        .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL)
    ) u_back (
        .clk, .rst_n, .cfg(cfg_reg), .q_item, .q_valid, .q_pop, .out_ch,
        .busy(bbusy)
    );

    logic unused_busy;
    assign unused_busy = fbusy & bbusy;
endmodule
`default_nettype wire

### rtl/core/cvs_checker.sv
// ----------------------------------------------------------------------------
// cvs_checker
// Port-level checks for the convolution core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "conv2d_valid_stride_mac_core_defines.svh"
module cvs_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [1:0]       out_status,
    input wire logic [31:0]      out_value
);
    `CVS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status <= cvs_pkg::ST_RANGE)
    `CVS_ASSERT_IMP(a_range_zero, clk, rst_n, out_valid && out_status == cvs_pkg::ST_RANGE, out_value == 32'd0)
    `CVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value))
    `CVS_ASSERT_IMP(a_sat_limit, clk, rst_n, out_valid && out_status == cvs_pkg::ST_SAT, out_value == 32'h7FFF_FFFF || out_value == 32'h8000_0000)
endmodule

bind conv2d_valid_stride_mac_core cvs_checker u_cvs_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data.status), .out_value(out_ch.data.result_value)
);
`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Convolution core bench. Loads a small window of pixels and weights, then
// issues directed computes and a random mix of loads and computes under
// several kernel, channel and stride settings. A local predictor keeps its
// own stores and checks each result value and status in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int NROWS = 64;
    localparam int NCOLS = 64;
    localparam int NCH   = 16;
    localparam int NFILT = 16;
    localparam int NK    = 5;

    logic clk;
    logic rst_n;

    cvs_item_if   in_ch ();
    cvs_result_if out_ch ();
    cvs_cfg_if    cfg_ch ();

    conv2d_valid_stride_mac_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    logic signed [15:0] pixel_mem [NROWS*NCOLS*NCH];
    logic signed [15:0] weight_mem [NFILT*NK*NK*NCH];
    logic signed [15:0] bias_mem [NFILT];
    cvs_pkg::cfg_t    cur_cfg;
    cvs_pkg::item_t   pending_items[$];
    cvs_pkg::result_t expected_results[$];
    int      errors;
    int      sent_count;
    int      in_gap;
    int      out_gap;
    bit      in_taken;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #500ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic cvs_pkg::result_t conv_predict(cvs_pkg::item_t it);
        cvs_pkg::result_t res;
        int unsigned nc;
        int unsigned kr;
        int unsigned kc;
        int unsigned y0;
        int unsigned x0;
        longint sum;
        res.result_value = '0;
        res.status = cvs_pkg::ST_OK;
        nc = (cur_cfg.channels_in_use > NCH) ? NCH : cur_cfg.channels_in_use;
        kr = (cur_cfg.kernel_rows > NK) ? NK : cur_cfg.kernel_rows;
        kc = (cur_cfg.kernel_cols > NK) ? NK : cur_cfg.kernel_cols;
        y0 = it.row * cur_cfg.row_step;
        x0 = it.col * cur_cfg.col_step;
        if ((kr > 0 && y0 + kr - 1 >= NROWS) || (kc > 0 && x0 + kc - 1 >= NCOLS))
        begin
            res.status = cvs_pkg::ST_RANGE;
            return res;
        end
        sum = longint'(bias_mem[it.filt]) * 256;
        for (int ky = 0; ky < kr; ky++)
            for (int kx = 0; kx < kc; kx++)
                for (int c = 0; c < nc; c++)
                    sum += longint'(pixel_mem[((y0 + ky) * NCOLS + x0 + kx) * NCH + c])
                        * longint'(weight_mem[((it.filt * NK + ky) * NK + kx) * NCH + c]);
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            res.status = cvs_pkg::ST_SAT;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            res.status = cvs_pkg::ST_SAT;
        end
        res.result_value = sum[31:0];
        return res;
    endfunction

    task automatic apply_item(cvs_pkg::item_t it);
        case (it.op)
            cvs_pkg::OP_LOAD_IN:
                pixel_mem[(it.row * NCOLS + it.col) * NCH + it.chan] = it.value;
            cvs_pkg::OP_LOAD_W:
                if (it.row < NK && it.col < NK)
                    weight_mem[((it.filt * NK + it.row) * NK + it.col) * NCH + it.chan]
                        = it.value;
            cvs_pkg::OP_LOAD_BIAS:
                bias_mem[it.filt] = it.value;
            default:
                expected_results.push_back(conv_predict(it));
        endcase
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (in_taken)
                begin
                    in_taken = 1'b0;
                    in_gap = $urandom_range(0, 19);
                    if ($urandom_range(0, 3) == 0)
                        in_gap = 0;
                end
                if (in_gap == 0 && pending_items.size() > 0)
                begin
                    in_ch.data  <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
            end
            if (out_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                out_gap--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cvs_pkg::result_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_item(in_ch.data);
                sent_count++;
                in_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_gap = $urandom_range(0, 19);
                if ($urandom_range(0, 3) == 0)
                    out_gap = 0;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result %h", out_ch.data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.data.result_value !== want.result_value)
                    begin
                        $error("result_value expected %h actual %h",
                            want.result_value, out_ch.data.result_value);
                        errors++;
                    end
                    if (out_ch.data.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d",
                            want.status, out_ch.data.status);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic cvs_pkg::item_t make_item(logic [1:0] op, int r, int c, int ch,
                                                 int f, int v);
        cvs_pkg::item_t it;
        it.op    = op;
        it.row   = 6'(r);
        it.col   = 6'(c);
        it.chan  = 4'(ch);
        it.filt  = 4'(f);
        it.value = 16'(v);
        return it;
    endfunction

    task automatic write_reg(logic [2:0] idx, int v);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.wdata <= 16'(v);
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            cvs_pkg::REG_CHANNELS: cur_cfg.channels_in_use = 5'(v);
            cvs_pkg::REG_KROWS:    cur_cfg.kernel_rows = 3'(v);
            cvs_pkg::REG_KCOLS:    cur_cfg.kernel_cols = 3'(v);
            cvs_pkg::REG_RSTEP:    cur_cfg.row_step = 3'(v);
            cvs_pkg::REG_CSTEP:    cur_cfg.col_step = 3'(v);
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic set_config(int nc, int kr, int kc, int rs, int cs);
        write_reg(cvs_pkg::REG_CHANNELS, nc);
        write_reg(cvs_pkg::REG_KROWS, kr);
        write_reg(cvs_pkg::REG_KCOLS, kc);
        write_reg(cvs_pkg::REG_RSTEP, rs);
        write_reg(cvs_pkg::REG_CSTEP, cs);
    endtask

    // load the pixel window and the kernels that the following computes read
    task automatic queue_fill(int nrows, int ncols, int nch, int nfilt, bit extreme);
        int v;
        for (int r = 0; r < nrows; r++)
            for (int c = 0; c < ncols; c++)
                for (int ch = 0; ch < nch; ch++)
                begin
                    v = extreme ? (($urandom_range(0, 1) != 0) ? 32767 : -32768)
                                : $urandom_range(0, 65535);
                    pending_items.push_back(make_item(cvs_pkg::OP_LOAD_IN, r, c, ch, 0, v));
                end
        for (int f = 0; f < nfilt; f++)
            for (int kr = 0; kr < NK; kr++)
                for (int kc = 0; kc < NK; kc++)
                    for (int ch = 0; ch < nch; ch++)
                    begin
                        v = extreme ? (($urandom_range(0, 1) != 0) ? 32767 : -32768)
                                    : $urandom_range(0, 65535);
                        pending_items.push_back(
                            make_item(cvs_pkg::OP_LOAD_W, kr, kc, ch, f, v));
                    end
    endtask

    task automatic queue_random(int count, int max_row, int max_col, int max_filt);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pending_items.push_back(make_item(cvs_pkg::OP_LOAD_BIAS, 0, 0, 0,
                    $urandom_range(0, 15), $urandom_range(0, 65535)));
            else if (pick == 1)
                pending_items.push_back(make_item(cvs_pkg::OP_LOAD_W, $urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 65535)));
            else if (pick == 2)
                pending_items.push_back(make_item(cvs_pkg::OP_LOAD_IN, $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 65535)));
            else if (pick == 3)
                pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 63,
                    $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 65535)));
            else
                pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE,
                    $urandom_range(0, max_row), $urandom_range(0, max_col),
                    $urandom_range(0, 15), $urandom_range(0, max_filt),
                    $urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        errors = 0;
        sent_count = 0;
        in_gap = 0;
        out_gap = 0;
        in_taken = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = cvs_pkg::REG_CHANNELS;
        cfg_ch.wdata = '0;
        cur_cfg = '{channels_in_use: 5'd1, kernel_rows: 3'd3, kernel_cols: 3'd3,
                    row_step: 3'd1, col_step: 3'd1};
        foreach (bias_mem[i])
            bias_mem[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, zero bias, windows near the edge of the map
        queue_fill(6, 6, 1, 4, 1'b0);
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 0, 0, 0, 3, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 3, 3, 0, 0, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 62, 0, 0, 0, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 0, 62, 0, 0, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_LOAD_BIAS, 0, 0, 0, 3, 32767));
        pending_items.push_back(make_item(cvs_pkg::OP_LOAD_BIAS, 0, 0, 0, 0, -32768));
        pending_items.push_back(make_item(cvs_pkg::OP_LOAD_W, 5, 7, 15, 2, 1234));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 3, 3, 15, 3, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 1, 2, 0, 0, -1));
        queue_random(100, 3, 3, 3);
        drain();

        // full kernel, two channels, saturating data, strides of four
        set_config(2, 5, 5, 4, 4);
        queue_fill(9, 9, 2, 2, 1'b1);
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 1, 1, 0, 0, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 15, 0, 0, 1, 0));
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 0, 15, 0, 1, 0));
        queue_random(60, 1, 1, 1);
        drain();

        // oversized register values clamp; zero-size kernel gives bias only
        set_config(31, 7, 0, 0, 2);
        pending_items.push_back(make_item(cvs_pkg::OP_COMPUTE, 63, 63, 0, 4, 0));
        queue_random(80, 63, 63, 15);
        drain();

        set_config(0, 1, 1, 7, 1);
        queue_random(80, 63, 63, 15);
        drain();

        set_config(2, 3, 2, 1, 3);
        queue_random(150, 6, 2, 1);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
